>>> sv/tcw_pkg.sv
// Shared types and constants of the text console write engine.
package tcw_pkg;

	// Command codes of an input transaction
	typedef enum logic [2:0] {
		CMD_TYPED   = 3'd0,
		CMD_RAW     = 3'd1,
		CMD_NEWLINE = 3'd2,
		CMD_CLEAR   = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEXT_ATTR = 2'd0,
		CFG_COL_FLOOR = 2'd1,
		CFG_ROW_FLOOR = 2'd2
	} cfg_idx_t;

	// Field widths fixed by the interface
	localparam int CMD_W  = 3;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = CHAR_W + ATTR_W;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

	// Reset values of the configuration registers
	localparam logic [ATTR_W-1:0] RESET_ATTR      = 8'h0F;
	localparam logic [COL_W-1:0]  RESET_COL_FLOOR = 7'd11;
	localparam logic [ROW_W-1:0]  RESET_ROW_FLOOR = 5'd4;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

endpackage

>>> sv/tcw_if.sv
// Request and response channel interfaces of the text console write engine.
interface tcw_req_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::CMD_W-1:0]     command;
	logic [tcw_pkg::CHAR_W-1:0]    char_code;
	logic [tcw_pkg::ROW_W-1:0]     read_row;
	logic [tcw_pkg::COL_W-1:0]     read_col;

	modport source(output valid, output command, output char_code, output read_row,
		output read_col, input ready);
	modport sink(input valid, input command, input char_code, input read_row,
		input read_col, output ready);
endinterface

interface tcw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::COL_W-1:0]     cursor_col;
	logic [tcw_pkg::ROW_W-1:0]     cursor_row;
	logic [tcw_pkg::CHAR_W-1:0]    read_char;
	logic [tcw_pkg::ATTR_W-1:0]    read_attr;

	modport source(output valid, output cursor_col, output cursor_row, output read_char,
		output read_attr, input ready);
	modport sink(input valid, input cursor_col, input cursor_row, input read_char,
		input read_attr, output ready);
endinterface

>>> sv/tcw_cell_ram.sv
// Single-port-write, single-port-read cell memory with registered read data.
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [tcw_pkg::CELL_W-1:0]    wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [tcw_pkg::CELL_W-1:0]    rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/text_console_write_engine.sv
// Top level of the text console write engine: sequencer, cursor and result register.
//
// Keeps a ROWS x COLUMNS store of character/attribute cells in one memory with
// one write and one read access per cycle, and a cursor. After reset the block
// runs a clearing pass over all ROWS*COLUMNS cells (2000 by default) with
// req.ready low; configuration writes are taken throughout. Every item returns
// one response. A plain write, newline without scroll, same-line or blocked
// backspace, unused command or out-of-range read goes straight to the response
// stage; an in-range cell read first waits for the registered memory data; a
// backspace onto the previous line scans that line leftward over spaces; a
// clear writes every cell; a newline or wrap on the bottom row copies every row
// up and then blanks the last row. The next item can be taken in the cycle
// after the response is loaded. A finished response waits in its own register
// so the next item can be accepted meanwhile.
module text_console_write_engine #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::CHAR_W-1:0]        cfg_data,
	tcw_req_if.sink                           req,
	tcw_rsp_if.source                         rsp
);
	import tcw_pkg::*;

	localparam int CELLS     = ROWS * COLUMNS;
	localparam int AW        = $clog2(CELLS);
	localparam int SW        = $clog2(CELLS + 1);
	localparam int CW        = $clog2(COLUMNS + 1);
	localparam int RW        = $clog2(ROWS);
	localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

	state_t state_q, state_d;

	logic [CW-1:0]     col_q, col_d;
	logic [RW-1:0]     row_q, row_d;
	logic [SW-1:0]     src_q, src_d;
	logic              pend_q, pend_d;
	logic [CHAR_W-1:0] char_q, char_d;
	logic [CHAR_W-1:0] rdc_q, rdc_d;
	logic [ATTR_W-1:0] rda_q, rda_d;
	logic              rv_s1, rv_d;
	logic [AW-1:0]     dst_s1, dst_d;

	logic [ATTR_W-1:0] text_attr_q;
	logic [COL_W-1:0]  col_floor_q;
	logic [ROW_W-1:0]  row_floor_q;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [ATTR_W-1:0] out_attr_q;
	logic              load_out;

	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	logic [CELL_W-1:0] wdata, rdata;

	logic              is_nl, is_bs, is_wr, rd_ok, at_bottom;

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
		addr_of = AW'(32'(r) * COLUMNS + 32'(c));
	endfunction

	tcw_cell_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Decode the incoming transaction
	always_comb begin
		is_nl = (req.command == CMD_NEWLINE) ||
			((req.command == CMD_TYPED) && (req.char_code == CH_NEWLINE));
		is_bs = (req.command == CMD_TYPED) && (req.char_code == CH_BACKSPACE);
		is_wr = (req.command == CMD_RAW) ||
			((req.command == CMD_TYPED) && !is_nl && !is_bs);
		rd_ok = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLUMNS);
		at_bottom = !(32'(row_q) < ROWS - 1);
	end

	// Sequencer: next state, memory accesses and cursor updates
	always_comb begin
		state_d  = state_q;
		col_d    = col_q;
		row_d    = row_q;
		src_d    = src_q;
		pend_d   = pend_q;
		char_d   = char_q;
		rdc_d    = rdc_q;
		rda_d    = rda_q;
		rv_d     = 1'b0;
		dst_d    = dst_s1;
		load_out = 1'b0;
		we       = 1'b0;
		waddr    = addr_of(row_q, col_q);
		wdata    = {text_attr_q, CH_SPACE};
		re       = 1'b0;
		raddr    = addr_of(row_q, col_q);
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = src_q[AW-1:0];
				wdata = {RESET_ATTR, CH_SPACE};
				if (32'(src_q) == CELLS - 1) begin
					src_d   = '0;
					state_d = ST_IDLE;
				end else begin
					src_d = SW'(src_q + 1'b1);
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					rdc_d   = '0;
					rda_d   = '0;
					state_d = ST_DONE;
					if (is_nl) begin
						col_d = '0;
						if (!at_bottom) begin
							row_d = RW'(row_q + 1'b1);
						end else begin
							src_d   = SW'(COLUMNS);
							pend_d  = 1'b0;
							state_d = ST_SCROLL;
						end
					end else if (is_wr) begin
						char_d = req.char_code;
						if (32'(col_q) >= COLUMNS) begin
							// Full line: new line first, then write in column 0
							if (!at_bottom) begin
								row_d = RW'(row_q + 1'b1);
								col_d = CW'(1);
								we    = 1'b1;
								waddr = addr_of(RW'(row_q + 1'b1), '0);
								wdata = {text_attr_q, req.char_code};
							end else begin
								col_d   = '0;
								src_d   = SW'(COLUMNS);
								pend_d  = 1'b1;
								state_d = ST_SCROLL;
							end
						end else begin
							we    = 1'b1;
							waddr = addr_of(row_q, col_q);
							wdata = {text_attr_q, req.char_code};
							col_d = CW'(col_q + 1'b1);
						end
					end else if (is_bs) begin
						if (32'(col_q) > 32'(col_floor_q)) begin
							col_d = CW'(col_q - 1'b1);
							we    = 1'b1;
							waddr = addr_of(row_q, CW'(col_q - 1'b1));
						end else if (32'(row_q) > 32'(row_floor_q)) begin
							row_d   = RW'(row_q - 1'b1);
							col_d   = CW'(COLUMNS - 1);
							state_d = ST_SCAN_RD;
						end
					end else if (req.command == CMD_CLEAR) begin
						src_d   = '0;
						state_d = ST_CLEAR;
					end else if (req.command == CMD_READ) begin
						if (rd_ok) begin
							re      = 1'b1;
							raddr   = addr_of(RW'(req.read_row), CW'(req.read_col));
							state_d = ST_READ_WAIT;
						end
					end
				end
			end
			ST_SCROLL: begin
				// Read one row ahead, write the cell read last cycle one row up
				if (32'(src_q) < CELLS) begin
					re    = 1'b1;
					raddr = src_q[AW-1:0];
					rv_d  = 1'b1;
					dst_d = AW'(32'(src_q) - COLUMNS);
					src_d = SW'(src_q + 1'b1);
				end else begin
					src_d   = '0;
					state_d = ST_BLANK;
				end
				if (rv_s1) begin
					we    = 1'b1;
					waddr = dst_s1;
					wdata = rdata;
				end
			end
			ST_BLANK: begin
				we    = 1'b1;
				waddr = AW'(LAST_BASE + 32'(src_q));
				if (pend_q && (src_q == '0)) begin
					wdata = {text_attr_q, char_q};
				end
				if (32'(src_q) == COLUMNS - 1) begin
					col_d   = pend_q ? CW'(1) : '0;
					src_d   = '0;
					state_d = ST_DONE;
				end else begin
					src_d = SW'(src_q + 1'b1);
				end
			end
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = src_q[AW-1:0];
				if (32'(src_q) == CELLS - 1) begin
					src_d   = '0;
					state_d = ST_DONE;
				end else begin
					src_d = SW'(src_q + 1'b1);
				end
			end
			ST_SCAN_RD: begin
				re      = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				// Step left over spaces, blank the cell where the scan stops
				if ((rdata[CHAR_W-1:0] == CH_SPACE) && (col_q != '0)) begin
					col_d   = CW'(col_q - 1'b1);
					state_d = ST_SCAN_RD;
				end else begin
					we      = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_READ_WAIT: begin
				rdc_d   = rdata[CHAR_W-1:0];
				rda_d   = rdata[CELL_W-1:CHAR_W];
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			col_q   <= '0;
			row_q   <= '0;
			src_q   <= '0;
			pend_q  <= 1'b0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			src_q   <= src_d;
			pend_q  <= pend_d;
			rv_s1   <= rv_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		char_q <= char_d;
		rdc_q  <= rdc_d;
		rda_q  <= rda_d;
		dst_s1 <= dst_d;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= RESET_ATTR;
			col_floor_q <= RESET_COL_FLOOR;
			row_floor_q <= RESET_ROW_FLOOR;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TEXT_ATTR: text_attr_q <= cfg_data;
				CFG_COL_FLOOR: col_floor_q <= cfg_data[COL_W-1:0];
				CFG_ROW_FLOOR: row_floor_q <= cfg_data[ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Response register: load when free or being drained, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_col_q  <= COL_W'(col_q);
			out_row_q  <= ROW_W'(row_q);
			out_char_q <= rdc_q;
			out_attr_q <= rda_q;
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.read_char  = out_char_q;
	assign rsp.read_attr  = out_attr_q;

endmodule
